// ===== rtl/rpmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmd_pkg
// Shared types and constants for the rational multiply/divide core.
// ----------------------------------------------------------------------------
package rpmd_pkg;

  localparam int unsigned FIELD_BITS    = 64;
  localparam int unsigned WORD_BITS_DEF = 64;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_G1,
    S_D1,
    S_D2,
    S_G2,
    S_D3,
    S_D4,
    S_M1,
    S_M2,
    S_G3,
    S_D5,
    S_D6,
    S_OUT
  } state_e;

  // Unit launch requests from the sequencer
  typedef struct packed {
    logic gcd;
    logic div;
    logic mul;
  } start_t;

endpackage

// ===== rtl/rpmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmd_in_if / rpmd_out_if
// Valid/ready channels for operand and result transactions.
// ----------------------------------------------------------------------------
interface rpmd_in_if import rpmd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [FIELD_BITS-1:0] a_num;
  logic [FIELD_BITS-1:0] a_den;
  logic [FIELD_BITS-1:0] b_num;
  logic [FIELD_BITS-1:0] b_den;

  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rpmd_out_if import rpmd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] res_num;
  logic [FIELD_BITS-1:0] res_den;
  logic [1:0]            status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

// ===== rtl/rpmd_gcd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmd_gcd
// Binary gcd, one shift or subtract per cycle.
// ----------------------------------------------------------------------------
module rpmd_gcd #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  output logic         done_o,
  output logic [W-1:0] g_o
);
  localparam int unsigned KW = (W > 1) ? $clog2(W) : 1;

  logic          busy_q, done_q;
  logic [W-1:0]  x_q, y_q, g_q;
  logic [KW-1:0] k_q;

  // Step the gcd reduction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (x_q == '0 || y_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      y_q <= y_i;
      k_q <= '0;
    end else if (busy_q) begin
      if (x_q == '0) begin
        g_q <= y_q << k_q;
      end else if (y_q == '0) begin
        g_q <= x_q << k_q;
      end else if (!x_q[0] && !y_q[0]) begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q >= y_q) begin
        x_q <= (x_q - y_q) >> 1;
      end else begin
        y_q <= (y_q - x_q) >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign g_o    = g_q;
endmodule

// ===== rtl/rpmd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpmd_div #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] n_i,
  input  logic [W-1:0] d_i,
  output logic         done_o,
  output logic [W-1:0] q_o
);
  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

  logic          busy_q, done_q;
  logic [W-1:0]  rem_q, quo_q, d_q;
  logic [CW-1:0] cnt_q;
  logic [W:0]    shifted, trial;

  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = shifted - {1'b0, d_q};

  // Sequence the bit iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift in one quotient bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= n_i;
      d_q   <= d_i;
    end else if (busy_q) begin
      rem_q <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], ~trial[W]};
    end
  end

  assign done_o = done_q;
  assign q_o    = quo_q;
endmodule

// ===== rtl/rpmd_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmd_mul
// Shift-add multiplier with overflow flag for the upper half.
// ----------------------------------------------------------------------------
module rpmd_mul #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  output logic         done_o,
  output logic         ovf_o,
  output logic [W-1:0] p_o
);
  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

  logic           busy_q, done_q;
  logic [2*W-1:0] acc_q, mcand_q;
  logic [W-1:0]   mplier_q;
  logic [CW-1:0]  cnt_q;

  // Sequence the partial products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Accumulate one multiplier bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= (2*W)'(x_i);
      mplier_q <= y_i;
    end else if (busy_q) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign done_o = done_q;
  assign ovf_o  = (acc_q[2*W-1:W] != '0);
  assign p_o    = acc_q[W-1:0];
endmodule

// ===== rtl/positive_rational_multiply_divide_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positive_rational_multiply_divide_core
// Cross-cancelled rational multiply/divide with final reduction.
// ----------------------------------------------------------------------------
// One transaction at a time: the core drops ready after accepting operands
// and raises it again once the result transaction is taken. The work runs on
// one binary gcd unit (up to three calls), one restoring divider (up to six
// calls) and one shift-add multiplier (up to two calls), all sequenced one
// after the other. The work done depends on the operands: a cancel is
// skipped when its gcd is zero, and the final reduction is skipped on
// overflow or a zero product. The result is held until ready is seen.
// Operand bits above WORD_BITS are ignored.
module positive_rational_multiply_divide_core import rpmd_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rpmd_in_if.sink          in_i,
  rpmd_out_if.source       out_o
);
  localparam int unsigned W = WORD_BITS;

  state_e       st_q, st_d;
  status_e      status_q;
  logic         run_q;
  logic [W-1:0] an_q, ad_q, bn_q, bd_q, pn_q, pd_q;
  start_t       start;

  logic [W-1:0] gcd_x, gcd_y, gcd_g, div_n, div_q, mul_x, mul_y, mul_p;
  logic         gcd_done, div_done, mul_done, mul_ovf;

  rpmd_gcd #(.W(W)) u_gcd (
    .clk_i, .rst_ni, .start_i(start.gcd), .x_i(gcd_x), .y_i(gcd_y),
    .done_o(gcd_done), .g_o(gcd_g)
  );

  rpmd_div #(.W(W)) u_div (
    .clk_i, .rst_ni, .start_i(start.div), .n_i(div_n), .d_i(gcd_g),
    .done_o(div_done), .q_o(div_q)
  );

  rpmd_mul #(.W(W)) u_mul (
    .clk_i, .rst_ni, .start_i(start.mul), .x_i(mul_x), .y_i(mul_y),
    .done_o(mul_done), .ovf_o(mul_ovf), .p_o(mul_p)
  );

  // Route operands to the shared units
  always_comb begin
    gcd_x = an_q;
    gcd_y = bd_q;
    div_n = an_q;
    mul_x = an_q;
    mul_y = bn_q;
    case (st_q)
      S_G2: begin gcd_x = bn_q; gcd_y = ad_q; end
      S_G3: begin gcd_x = pn_q; gcd_y = pd_q; end
      S_D2: div_n = bd_q;
      S_D3: div_n = bn_q;
      S_D4: div_n = ad_q;
      S_D5: div_n = pn_q;
      S_D6: div_n = pd_q;
      S_M2: begin mul_x = ad_q; mul_y = bd_q; end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (in_i.valid) st_d = S_G1;
      S_G1:   if (gcd_done) st_d = (gcd_g == '0) ? S_G2 : S_D1;
      S_D1:   if (div_done) st_d = S_D2;
      S_D2:   if (div_done) st_d = S_G2;
      S_G2:   if (gcd_done) st_d = (gcd_g == '0) ? S_M1 : S_D3;
      S_D3:   if (div_done) st_d = S_D4;
      S_D4:   if (div_done) st_d = S_M1;
      S_M1:   if (mul_done) st_d = mul_ovf ? S_OUT : S_M2;
      S_M2: begin
        if (mul_done) begin
          st_d = (mul_ovf || pn_q == '0 || mul_p == '0) ? S_OUT : S_G3;
        end
      end
      S_G3:   if (gcd_done) st_d = S_D5;
      S_D5:   if (div_done) st_d = S_D6;
      S_D6:   if (div_done) st_d = S_OUT;
      S_OUT:  if (out_o.ready) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // Unit launches and handshakes
  always_comb begin
    start.gcd = !run_q && (st_q == S_G1 || st_q == S_G2 || st_q == S_G3);
    start.div = !run_q && (st_q == S_D1 || st_q == S_D2 || st_q == S_D3 ||
                           st_q == S_D4 || st_q == S_D5 || st_q == S_D6);
    start.mul = !run_q && (st_q == S_M1 || st_q == S_M2);
    in_i.ready  = (st_q == S_IDLE);
    out_o.valid = (st_q == S_OUT);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      run_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (start.gcd || start.div || start.mul) begin
        run_q <= 1'b1;
      end else if (gcd_done || div_done || mul_done) begin
        run_q <= 1'b0;
      end
    end
  end

  // Operand and result datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (in_i.valid) begin
          an_q     <= in_i.a_num[W-1:0];
          ad_q     <= in_i.a_den[W-1:0];
          bn_q     <= in_i.opcode ? in_i.b_den[W-1:0] : in_i.b_num[W-1:0];
          bd_q     <= in_i.opcode ? in_i.b_num[W-1:0] : in_i.b_den[W-1:0];
          status_q <= ST_OK;
        end
      end
      S_D1: if (div_done) an_q <= div_q;
      S_D2: if (div_done) bd_q <= div_q;
      S_D3: if (div_done) bn_q <= div_q;
      S_D4: if (div_done) ad_q <= div_q;
      S_D5: if (div_done) pn_q <= div_q;
      S_D6: if (div_done) pd_q <= div_q;
      S_M1: begin
        if (mul_done) begin
          pn_q <= mul_ovf ? '0 : mul_p;
          pd_q <= '0;
          if (mul_ovf) status_q <= ST_OVF;
        end
      end
      S_M2: begin
        if (mul_done) begin
          if (mul_ovf) begin
            status_q <= ST_OVF;
            pn_q     <= '0;
            pd_q     <= '0;
          end else if (pn_q == '0 || mul_p == '0) begin
            status_q <= ST_ZERO;
            pn_q     <= '0;
            pd_q     <= '0;
          end else begin
            pd_q <= mul_p;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_o.res_num = FIELD_BITS'(pn_q);
  assign out_o.res_den = FIELD_BITS'(pd_q);
  assign out_o.status  = status_q;

  // Error results carry zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && status_q != ST_OK) |-> (pn_q == '0 && pd_q == '0))
    else $error("error result with nonzero fields");

  // A good result never has a zero numerator or denominator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && status_q == ST_OK) |-> (pd_q != '0 && pn_q != '0))
    else $error("ok result with zero part");

  // Only one shared unit launches at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({start.gcd, start.div, start.mul}))
    else $error("multiple unit launches");

  // No launch while a unit is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> !(start.gcd || start.div || start.mul))
    else $error("launch while unit busy");
endmodule
